### rtl/rpba_pkg.sv
// Shared types, codes and CRC-8 helpers for the rumble pak block access logic.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package rpba_pkg;

    // Block geometry and counter width for the write byte count and read index
    localparam int BLOCK_BYTES = 32;
    localparam int CNT_W       = $clog2(BLOCK_BYTES + 1);

    // Protocol constants
    localparam logic [7:0]  CRC_POLY        = 8'h85;
    localparam logic [7:0]  ADDR_MASK_LOW   = 8'hE0;
    localparam logic [15:0] READ_RANGE_LOW  = 16'h8000;
    localparam logic [15:0] READ_RANGE_HIGH = 16'h9000;
    localparam logic [15:0] RUMBLE_ADDR     = 16'hC000;
    localparam logic [7:0]  READ_FILL       = 8'h80;

    // Command codes
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Result kind codes
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_CRC     = 2'd1;
    localparam logic [1:0] KIND_IGNORED = 2'd2;

    // Rumble action codes
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    // One input word
    typedef struct packed {
        logic       command;
        logic [1:0] port;
        logic [7:0] address_high;
        logic [7:0] address_low;
        logic [7:0] data_byte;
        logic       final_byte;
    } item_t;

    // One result word
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_out;
        logic [1:0] rumble_action;
        logic [1:0] rumble_port;
        logic       end_of_run;
    } result_t;

    // Byte-wide CRC-8 step, MSB first, no reflection
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // CRC of a whole block filled with one byte value (elaboration only)
    function automatic logic [7:0] crc8_fill(input logic [7:0] fill);
        logic [7:0] c;
        c = 8'h00;
        for (int k = 0; k < BLOCK_BYTES; k++) begin
            c = crc8_update(c, fill);
        end
        return c;
    endfunction

    localparam logic [7:0] READ_CRC_FILL = crc8_fill(READ_FILL);
    localparam logic [7:0] READ_CRC_ZERO = crc8_fill(8'h00);

endpackage

`default_nettype wire

### rtl/rpba_in_reg.sv
// Input holding register: takes one word from the input channel and keeps it
// until the engine has finished with it. Depends on rpba_pkg.
`default_nettype none

module rpba_in_reg (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire rpba_pkg::item_t s_item,
    input  wire logic           consume,
    output logic                hold_valid,
    output rpba_pkg::item_t     hold_item
);

    logic            valid_reg;
    logic            valid_next;
    rpba_pkg::item_t item_reg;

    // Accept when empty or when the held word leaves this cycle
    assign s_ready = !valid_reg || consume;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (consume) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on acceptance
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

endmodule

`default_nettype wire

### rtl/rpba_engine.sv
// Access engine: port mask register, write-block CRC state and read sequencer.
// Turns the held input word into result words. Depends on rpba_pkg.
`default_nettype none

module rpba_engine (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [3:0]      cfg_data,
    input  wire logic            item_valid,
    input  wire rpba_pkg::item_t item,
    input  wire logic            out_free,
    output logic                 consume,
    output logic                 emit,
    output rpba_pkg::result_t    result
);

    logic [3:0]                 mask_reg;
    logic [7:0]                 crc_reg;
    logic [7:0]                 crc_next;
    logic [7:0]                 first_reg;
    logic [7:0]                 first_next;
    logic [rpba_pkg::CNT_W-1:0] wr_cnt_reg;
    logic [rpba_pkg::CNT_W-1:0] wr_cnt_next;
    logic [rpba_pkg::CNT_W-1:0] rd_idx_reg;
    logic [rpba_pkg::CNT_W-1:0] rd_idx_next;

    logic                       present;
    logic [15:0]                addr;
    logic                       in_range;
    logic [7:0]                 wr_crc;
    logic [7:0]                 wr_first;
    logic [rpba_pkg::CNT_W-1:0] wr_cnt_inc;
    logic                       wr_done;
    logic                       rd_last;

    // Configuration is always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= 4'h0;
        end else if (cfg_valid) begin
            mask_reg <= cfg_data;
        end
    end

    // Decode the held word
    assign present    = mask_reg[item.port];
    assign addr       = {item.address_high, item.address_low & rpba_pkg::ADDR_MASK_LOW};
    assign in_range   = (addr >= rpba_pkg::READ_RANGE_LOW) && (addr < rpba_pkg::READ_RANGE_HIGH);
    assign wr_crc     = rpba_pkg::crc8_update(crc_reg, item.data_byte);
    assign wr_first   = (wr_cnt_reg == '0) ? item.data_byte : first_reg;
    assign wr_cnt_inc = wr_cnt_reg + rpba_pkg::CNT_W'(1);
    assign wr_done    = item.final_byte ||
                        (wr_cnt_inc >= rpba_pkg::CNT_W'(rpba_pkg::BLOCK_BYTES));
    assign rd_last    = (rd_idx_reg == rpba_pkg::CNT_W'(rpba_pkg::BLOCK_BYTES));

    // Build the result word and the next write/read state
    always_comb begin
        consume     = 1'b0;
        emit        = 1'b0;
        result      = '0;
        crc_next    = crc_reg;
        first_next  = first_reg;
        wr_cnt_next = wr_cnt_reg;
        rd_idx_next = rd_idx_reg;
        if (item_valid) begin
            if (!present) begin
                // No pak on this port: one ignored word, write state untouched
                emit              = out_free;
                consume           = out_free;
                result.kind       = rpba_pkg::KIND_IGNORED;
                result.end_of_run = 1'b1;
            end else if (item.command == rpba_pkg::CMD_READ) begin
                // Stream fill bytes (zeros outside the read range), then the block CRC
                emit    = out_free;
                consume = out_free && rd_last;
                if (rd_last) begin
                    result.kind       = rpba_pkg::KIND_CRC;
                    result.byte_out   = in_range ? rpba_pkg::READ_CRC_FILL
                                                 : rpba_pkg::READ_CRC_ZERO;
                    result.end_of_run = 1'b1;
                end else begin
                    result.kind     = rpba_pkg::KIND_DATA;
                    result.byte_out = in_range ? rpba_pkg::READ_FILL : 8'h00;
                end
                if (out_free) begin
                    rd_idx_next = rd_last ? '0 : rd_idx_reg + rpba_pkg::CNT_W'(1);
                end
            end else begin
                // Accumulate a write byte; close the block on its last byte
                if (wr_done) begin
                    emit              = out_free;
                    consume           = out_free;
                    result.kind       = rpba_pkg::KIND_CRC;
                    result.byte_out   = wr_crc;
                    result.end_of_run = 1'b1;
                    if (addr == rpba_pkg::RUMBLE_ADDR) begin
                        result.rumble_action = (wr_first != 8'h00) ? rpba_pkg::ACT_START
                                                                   : rpba_pkg::ACT_STOP;
                        result.rumble_port   = item.port;
                    end
                    if (out_free) begin
                        crc_next    = 8'h00;
                        first_next  = 8'h00;
                        wr_cnt_next = '0;
                    end
                end else begin
                    consume     = 1'b1;
                    crc_next    = wr_crc;
                    first_next  = wr_first;
                    wr_cnt_next = wr_cnt_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg    <= 8'h00;
            first_reg  <= 8'h00;
            wr_cnt_reg <= '0;
            rd_idx_reg <= '0;
        end else begin
            crc_reg    <= crc_next;
            first_reg  <= first_next;
            wr_cnt_reg <= wr_cnt_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

`ifndef SYNTH
    a_rd_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_idx_reg <= rpba_pkg::CNT_W'(rpba_pkg::BLOCK_BYTES))
        else $error("read index beyond block");

    a_wr_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_cnt_reg < rpba_pkg::CNT_W'(rpba_pkg::BLOCK_BYTES))
        else $error("write count not cleared at block end");

    a_rd_ends_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && present && item.command == rpba_pkg::CMD_READ) |->
            (emit && result.kind == rpba_pkg::KIND_CRC && result.end_of_run))
        else $error("read released without its CRC word");

    a_rd_idx_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_idx_reg != '0) |-> (item_valid && item.command == rpba_pkg::CMD_READ))
        else $error("read sequence running without a held read");

    a_eor_consumes: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && result.end_of_run) |-> consume)
        else $error("last word emitted but input word kept");
`endif

endmodule

`default_nettype wire

### rtl/rpba_out_reg.sv
// Output register: holds one result word until the consumer takes it.
// Depends on rpba_pkg.
`default_nettype none

module rpba_out_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              emit,
    input  wire rpba_pkg::result_t result,
    output logic                   out_free,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rpba_pkg::result_t      m_result
);

    logic              valid_reg;
    logic              valid_next;
    rpba_pkg::result_t result_reg;

    // Load when empty or when the current word is taken this cycle
    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (out_free) begin
            valid_next = emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && emit) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

`default_nettype wire

### rtl/rumble_pak_block_access.sv
// Top level of the rumble pak block access logic.
// Depends on rpba_pkg, rpba_in_reg, rpba_engine and rpba_out_reg.
`default_nettype none

// Answers controller pak block accesses for up to four ports. Each input word
// passes an input register, the access engine and an output register, which
// holds each result word until it is taken. A write byte that does not end
// its block gives no result; a byte that ends a block gives one CRC word, and
// an access to a port whose bit in the mask register is clear gives one
// ignored word. A block read occupies the engine, giving one result word per
// cycle while the result port is free (32 data bytes, fill bytes inside the
// read range and zeros outside it, then the CRC), paced by the single-word
// result port. The mask register is written through the cfg channel, which is always ready.
module rumble_pak_block_access (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // configuration
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [3:0] cfg_data,
    // input words
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_command,
    input  wire logic [1:0] s_port,
    input  wire logic [7:0] s_address_high,
    input  wire logic [7:0] s_address_low,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_final_byte,
    // result words
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_kind,
    output logic [7:0]      m_byte_out,
    output logic [1:0]      m_rumble_action,
    output logic [1:0]      m_rumble_port,
    output logic            m_end_of_run
);

    rpba_pkg::item_t   s_item;
    rpba_pkg::item_t   hold_item;
    rpba_pkg::result_t eng_result;
    rpba_pkg::result_t m_result;
    logic              hold_valid;
    logic              consume;
    logic              emit;
    logic              out_free;

    // Pack the input word
    assign s_item.command      = s_command;
    assign s_item.port         = s_port;
    assign s_item.address_high = s_address_high;
    assign s_item.address_low  = s_address_low;
    assign s_item.data_byte    = s_data_byte;
    assign s_item.final_byte   = s_final_byte;

    rpba_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .consume    (consume),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    rpba_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .item_valid (hold_valid),
        .item       (hold_item),
        .out_free   (out_free),
        .consume    (consume),
        .emit       (emit),
        .result     (eng_result)
    );

    rpba_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .emit     (emit),
        .result   (eng_result),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    // Unpack the result word
    assign m_kind          = m_result.kind;
    assign m_byte_out      = m_result.byte_out;
    assign m_rumble_action = m_result.rumble_action;
    assign m_rumble_port   = m_result.rumble_port;
    assign m_end_of_run    = m_result.end_of_run;

endmodule

`default_nettype wire
